// ===== design/dcdc_pkg.sv =====
// ---------------------------------------------------------------------------
// dcdc_pkg
// Shared types, constants and calendar tables for the day count / date
// converter.
// ---------------------------------------------------------------------------
package dcdc_pkg;

    localparam int CNT_W   = 20;
    localparam int YIN_W   = 12;
    localparam int YEAR_W  = 13;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;
    localparam int Y400_W  = 9;

    localparam int EPOCH_YEAR = 1980;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR_C = YEAR_W'(EPOCH_YEAR);
    localparam logic [Y400_W-1:0] EPOCH_MOD400 = Y400_W'(EPOCH_YEAR % 400);

    localparam logic [CNT_W-1:0] DAYS_400Y = CNT_W'(365 * 400 + 97);
    localparam logic [CNT_W-1:0] DAYS_100Y = CNT_W'(365 * 100 + 24);
    localparam logic [CNT_W-1:0] DAYS_4Y   = CNT_W'(365 * 4);
    localparam logic [CNT_W-1:0] DAYS_1Y   = CNT_W'(365);

    localparam logic ACT_DECODE = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH,
        ST_SUM,
        ST_DONE
    } dcdc_state_t;

    // length of month, zero-based index
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] idx,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (idx)
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd30;
                4'd5:    len = 5'd30;
                4'd8:    len = 5'd30;
                4'd10:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // days in a common year before the first of a one-based month
    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] mon);
        logic [DOY_W-1:0] d;
        begin
            case (mon)
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== design/day_count_date_converter_core.sv =====
// ---------------------------------------------------------------------------
// day_count_date_converter_core
// Gregorian day count (from 1980-01-01) to calendar date and back.
//
// Input channel: in_valid / in_stall with action, count_in, year_in,
// month_in, day_in. Output channel: out_valid / out_stall with year_out,
// month_out, day_out, count_out, day_of_year, leap_year. One result beat
// per input beat, in order.
// One item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. A loop steps years in blocks of 400,
// 100, 4 or 1 through one shared add/subtract unit, then (decode only)
// steps months. The run time depends on the year and date, set mostly
// by the number of year steps.
// The output register holds a result while out_stall is high; a new item
// can be accepted meanwhile, and its result waits until the register frees.
// Reset (rst_n low, asynchronous) returns to idle and drops out_valid.
// ---------------------------------------------------------------------------
module day_count_date_converter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [dcdc_pkg::CNT_W-1:0]   count_in,
    input  logic [dcdc_pkg::YIN_W-1:0]   year_in,
    input  logic [dcdc_pkg::MON_W-1:0]   month_in,
    input  logic [dcdc_pkg::DAY_W-1:0]   day_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dcdc_pkg::YEAR_W-1:0]  year_out,
    output logic [dcdc_pkg::MON_W-1:0]   month_out,
    output logic [dcdc_pkg::DAY_W-1:0]   day_out,
    output logic [dcdc_pkg::CNT_W-1:0]   count_out,
    output logic [dcdc_pkg::DOY_W-1:0]   day_of_year,
    output logic                         leap_year
);
    import dcdc_pkg::*;

    dcdc_state_t        state_reg, state_next;
    logic               out_valid_reg, out_valid_next;

    logic               act_reg, act_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [Y400_W-1:0]  y400_reg, y400_next;
    logic [YIN_W-1:0]   diff_reg, diff_next;
    logic [MON_W-1:0]   mon_reg, mon_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [DOY_W-1:0]   doy_reg, doy_next;

    logic [YEAR_W-1:0]  year_out_reg, year_out_next;
    logic [MON_W-1:0]   month_out_reg, month_out_next;
    logic [DAY_W-1:0]   day_out_reg, day_out_next;
    logic [CNT_W-1:0]   count_out_reg, count_out_next;
    logic [DOY_W-1:0]   doy_out_reg, doy_out_next;
    logic               leap_out_reg, leap_out_next;

    logic               in_accept;
    logic               out_free;
    logic               leap, cent;
    logic [CNT_W-1:0]   len100, len4, len1;
    logic               fit400, fit100, fit4, fit1;
    logic               sub;
    logic [CNT_W-1:0]   op;
    logic [CNT_W-1:0]   sum;
    logic [Y400_W-1:0]  ystep;
    logic [Y400_W:0]    ysum;
    logic [YIN_W-1:0]   year_c;
    logic [MON_W-1:0]   mon_c;
    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   day_fix;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign year_out    = year_out_reg;
    assign month_out   = month_out_reg;
    assign day_out     = day_out_reg;
    assign count_out   = count_out_reg;
    assign day_of_year = doy_out_reg;
    assign leap_year   = leap_out_reg;

    // year mod 400 drives the leap and alignment tests
    assign cent = (y400_reg == 9'd0) || (y400_reg == 9'd100) ||
                  (y400_reg == 9'd200) || (y400_reg == 9'd300);
    assign leap = (y400_reg[1:0] == 2'd0) &&
                  !((y400_reg == 9'd100) || (y400_reg == 9'd200) || (y400_reg == 9'd300));

    assign len100 = DAYS_100Y + CNT_W'(leap);
    assign len4   = DAYS_4Y + CNT_W'(leap);
    assign len1   = DAYS_1Y + CNT_W'(leap);

    assign fit400 = act_reg ? (diff_reg >= 12'd400) : (acc_reg >= DAYS_400Y);
    assign fit100 = cent && (act_reg ? (diff_reg >= 12'd100) : (acc_reg >= len100));
    assign fit4   = (y400_reg[1:0] == 2'd0) &&
                    (act_reg ? (diff_reg >= 12'd4) : (acc_reg >= len4));
    assign fit1   = act_reg ? (diff_reg != 12'd0) : (acc_reg >= len1);

    // shared add/subtract unit
    assign sum  = sub ? (acc_reg - op) : (acc_reg + op);
    assign ysum = {1'b0, y400_reg} + {1'b0, ystep};

    assign year_c = (year_in < YIN_W'(EPOCH_YEAR)) ? YIN_W'(EPOCH_YEAR) : year_in;
    assign mon_c  = ((month_in == 4'd0) || (month_in > 4'd12)) ? 4'd1 : month_in;

    assign mlen    = (state_reg == ST_MONTHS) ? month_len(mon_reg, leap)
                                              : month_len(mon_reg - 4'd1, leap);
    assign day_fix = ((day_reg == 5'd0) || (day_reg > mlen)) ? 5'd1 : day_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        act_next       = act_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        year_next      = year_reg;
        y400_next      = y400_reg;
        diff_next      = diff_reg;
        mon_next       = mon_reg;
        day_next       = day_reg;
        doy_next       = doy_reg;
        year_out_next  = year_out_reg;
        month_out_next = month_out_reg;
        day_out_next   = day_out_reg;
        count_out_next = count_out_reg;
        doy_out_next   = doy_out_reg;
        leap_out_next  = leap_out_reg;
        sub            = 1'b1;
        op             = '0;
        ystep          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next   = action;
                    count_next = count_in;
                    acc_next   = (action == ACT_DECODE) ? count_in : '0;
                    year_next  = EPOCH_YEAR_C;
                    y400_next  = EPOCH_MOD400;
                    diff_next  = year_c - YIN_W'(EPOCH_YEAR);
                    mon_next   = mon_c;
                    day_next   = day_in;
                    state_next = ST_YEARS;
                end
            end

            ST_YEARS:
            begin
                sub = (act_reg == ACT_DECODE);
                if (fit400)
                begin
                    op    = DAYS_400Y;
                    ystep = 9'd400;
                end
                else if (fit100)
                begin
                    op    = len100;
                    ystep = 9'd100;
                end
                else if (fit4)
                begin
                    op    = len4;
                    ystep = 9'd4;
                end
                else if (fit1)
                begin
                    op    = len1;
                    ystep = 9'd1;
                end

                if (fit400 || fit100 || fit4 || fit1)
                begin
                    acc_next  = sum;
                    year_next = year_reg + YEAR_W'(ystep);
                    diff_next = diff_reg - YIN_W'(ystep);
                    y400_next = (ysum >= 10'd400) ? Y400_W'(ysum - 10'd400)
                                                  : ysum[Y400_W-1:0];
                end
                else if (act_reg == ACT_DECODE)
                begin
                    doy_next   = acc_reg[DOY_W-1:0];
                    mon_next   = 4'd0;
                    state_next = ST_MONTHS;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_MONTHS:
            begin
                // mon_reg is the zero-based month under test
                op = CNT_W'(mlen);
                if ((mon_reg < 4'd11) && (acc_reg >= CNT_W'(mlen)))
                begin
                    acc_next = sum;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    mon_next   = mon_reg + 4'd1;
                    day_next   = acc_reg[DAY_W-1:0] + 5'd1;
                    state_next = ST_DONE;
                end
            end

            ST_FINISH:
            begin
                day_next   = day_fix;
                doy_next   = days_before(mon_reg)
                           + DOY_W'(leap && (mon_reg > 4'd2))
                           + DOY_W'(day_fix) - 9'd1;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                sub        = 1'b0;
                op         = CNT_W'(doy_reg);
                acc_next   = sum;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    year_out_next  = year_reg;
                    month_out_next = mon_reg;
                    day_out_next   = day_reg;
                    count_out_next = (act_reg == ACT_ENCODE) ? acc_reg : count_reg;
                    doy_out_next   = doy_reg;
                    leap_out_next  = leap;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        acc_reg       <= acc_next;
        count_reg     <= count_next;
        year_reg      <= year_next;
        y400_reg      <= y400_next;
        diff_reg      <= diff_next;
        mon_reg       <= mon_next;
        day_reg       <= day_next;
        doy_reg       <= doy_next;
        year_out_reg  <= year_out_next;
        month_out_reg <= month_out_next;
        day_out_reg   <= day_out_next;
        count_out_reg <= count_out_next;
        doy_out_reg   <= doy_out_next;
        leap_out_reg  <= leap_out_next;
    end

endmodule
